// ===== hdl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and constants of the double-ended queue: opcodes, status
// codes and the command group from the controller to the datapath
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5,
        OP_QRY_EMPTY  = 3'd6,
        OP_QRY_FULL   = 3'd7
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted item
        logic exec;     // run the operation on the queue state
        logic load;     // move the result into the output register
    } t_dq_cmd;

endpackage

// ===== hdl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// bounded double-ended queue over a circular buffer with head and count
// ----------------------------------------------------------------------------
// sequence: each item is accepted, executed, then loaded into the output
//   register; no new item is taken until the current one has been loaded,
//   and the read of the slot ram is registered
// the next item is taken while a finished result still waits on the output
// reset: synchronous active low; head and count go to zero, no clearing
//   pass, slot contents stay unwritten until pushed
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [VALUE_W-1:0]  i_value,
    // result item channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VALUE_W-1:0]  o_data,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_empty_flag,
    output logic                o_full_flag
);

    // commands from the sequencer to the datapath
    t_dq_cmd cmd;

    // sequencer: one item in flight, output valid kept here
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    // datapath: pointer arithmetic, slot ram and the result register
    dq_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_data       (o_data),
        .o_status     (o_status),
        .o_empty_flag (o_empty_flag),
        .o_full_flag  (o_full_flag)
    );

endmodule

// ===== hdl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// sequencer of the queue: accept, execute, load result; owns output valid
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_dq_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.load    = (r_state == S_LOAD) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // a result waiting under stall is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !o_cmd.load)
        else $error("result overwritten while stalled");

    // every load shows up as a valid result on the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("load not followed by valid result");

    // an accepted item is executed on the following cycle
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("accepted item not executed");

endmodule

// ===== hdl/dq_dpath.sv =====
// ----------------------------------------------------------------------------
// dq_dpath
// queue datapath: head pointer, occupancy count, slot ram, result register
// ----------------------------------------------------------------------------
module dq_dpath
    import dq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dq_cmd             i_cmd,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [VALUE_W-1:0]  i_value,
    output logic [VALUE_W-1:0]  o_data,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_empty_flag,
    output logic                o_full_flag
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    t_opcode            r_op;
    logic [VALUE_W-1:0] r_value;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    t_status            r_status, n_status;
    logic               r_hit;

    logic [VALUE_W-1:0] r_out_data;
    t_status            r_out_status;
    logic               r_out_empty;
    logic               r_out_full;

    logic                  is_empty, is_full, rear_read;
    logic [AW-1:0]         head_dec, head_inc, rear_pos;
    logic [CW-1:0]         rear_off;
    logic [SW-1:0]         rear_sum, rear_wrap;
    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;
    logic [VALUE_W-1:0]    rd_word;

    // value masked or extended to the stored width
    for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_wdata
        if (b < VALUE_W) begin : g_bit
            assign wdata[b] = r_value[b];
        end else begin : g_zero
            assign wdata[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < VALUE_W; b++) begin : g_rdata
        if (b < DATA_WIDTH) begin : g_bit
            assign rd_word[b] = rdata[b];
        end else begin : g_zero
            assign rd_word[b] = 1'b0;
        end
    end

    always_comb begin
        is_empty  = (r_count == '0);
        is_full   = (r_count == CW'(CAPACITY));
        rear_read = (r_op == OP_POP_REAR) || (r_op == OP_PEEK_REAR);
        head_dec  = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
        head_inc  = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
        // rear slot for a push is head+count, for a read head+count-1
        rear_off  = rear_read ? r_count - CW'(1) : r_count;
        rear_sum  = SW'(r_head) + SW'(rear_off);
        rear_wrap = (rear_sum >= SW'(CAPACITY)) ? rear_sum - SW'(CAPACITY) : rear_sum;
        rear_pos  = rear_wrap[AW-1:0];

        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = rear_pos;
        raddr    = r_head;

        case (r_op)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    waddr   = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            OP_PUSH_REAR: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re = 1'b1;
                    if (r_op == OP_POP_FRONT) begin
                        n_head  = head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            OP_POP_REAR, OP_PEEK_REAR: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re    = 1'b1;
                    raddr = rear_pos;
                    if (r_op == OP_POP_REAR) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        if (!i_cmd.exec) begin
            we = 1'b0;
            re = 1'b0;
        end
    end

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_opcode'(i_opcode);
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_hit    <= re;
        end
        // flags come from the count already updated by the execute step
        if (i_cmd.load) begin
            r_out_data   <= r_hit ? rd_word : '0;
            r_out_status <= r_status;
            r_out_empty  <= (r_count == '0);
            r_out_full   <= (r_count == CW'(CAPACITY));
        end
    end

    assign o_data       = r_out_data;
    assign o_status     = r_out_status;
    assign o_empty_flag = r_out_empty;
    assign o_full_flag  = r_out_full;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < AW'(CAPACITY - 1) || r_head == AW'(CAPACITY - 1))
        else $error("head pointer out of range");

    // a rejected operation leaves the queue state untouched
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status != ST_OK) |=> ($stable(r_count) && $stable(r_head)))
        else $error("rejected operation changed queue state");

endmodule
